>>> rtl/core/hsv_to_rgb_converter_defines.svh
// Assertion macros for the HSV to RGB converter.
// Needs signals named clk and arst_n in the module that uses them.
`ifndef HSV_TO_RGB_CONVERTER_DEFINES_SVH
`define HSV_TO_RGB_CONVERTER_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define HSV2RGB_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define HSV2RGB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/hsv2rgb_pkg.sv
// Shared constants and types for the HSV to RGB converter.
// No dependencies.
package hsv2rgb_pkg;

	localparam int HUE_W = 9;
	localparam int PCT_W = 7;
	localparam int CHAN_W = 8;

	localparam int PCT_DEPTH = 2 ** PCT_W;
	localparam int KIDX_W = 6;
	localparam int K_DEPTH = 2 ** KIDX_W;

	localparam logic [HUE_W-1:0] HUE_MAX = 9'd360;
	localparam logic [HUE_W-1:0] HUE_60 = 9'd60;
	localparam logic [HUE_W-1:0] HUE_120 = 9'd120;
	localparam logic [HUE_W-1:0] HUE_180 = 9'd180;
	localparam logic [HUE_W-1:0] HUE_240 = 9'd240;
	localparam logic [HUE_W-1:0] HUE_300 = 9'd300;

	localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;
	localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

	typedef enum logic [2:0] {
		SEXT_0 = 3'd0,
		SEXT_1 = 3'd1,
		SEXT_2 = 3'd2,
		SEXT_3 = 3'd3,
		SEXT_4 = 3'd4,
		SEXT_5 = 3'd5
	} sext_t;

endpackage

>>> rtl/core/hsv_to_rgb_converter.sv
// HSV to RGB converter, four-stage pipeline.
// An accepted item passes the stage 1, 2, 3 and 4 registers in order; out_valid rises as it enters stage 4.
// Throughput: one item per cycle while out_ready holds high; each stage advances on its own when free.
// Reset clears only the stage valid bits; data registers are not reset.
// Depends on hsv2rgb_pkg, hsv2rgb_chan and hsv_to_rgb_converter_defines.svh.
`include "hsv_to_rgb_converter_defines.svh"

module hsv_to_rgb_converter import hsv2rgb_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [HUE_W-1:0]   hue_deg,
	input  logic [PCT_W-1:0]   sat_pct,
	input  logic [PCT_W-1:0]   val_pct,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [CHAN_W-1:0]  red,
	output logic [CHAN_W-1:0]  green,
	output logic [CHAN_W-1:0]  blue
);

	localparam int QW = FRAC_BITS + 1;

	// constant tables: percent to fraction, and hue ramp to fraction
	logic [QW-1:0] pct_lut [0:PCT_DEPTH-1];
	logic [QW-1:0] k_lut [0:K_DEPTH-1];

	for (genvar i = 0; i < PCT_DEPTH; i++) begin : g_pct
		localparam logic [QW-1:0] ENT = (i > PCT_MAX) ? '0 :
			QW'((64'(i) << FRAC_BITS) / PCT_MAX);
		assign pct_lut[i] = ENT;
	end

	for (genvar i = 0; i < K_DEPTH; i++) begin : g_k
		localparam logic [QW-1:0] ENT = (i > HUE_60) ? '0 :
			QW'((64'(i) << FRAC_BITS) / HUE_60);
		assign k_lut[i] = ENT;
	end

	logic en_s1, en_s2, en_s3, en_s4;
	logic valid_s1, valid_s2, valid_s3, valid_s4;

	assign en_s4 = !valid_s4 || out_ready;
	assign en_s3 = !valid_s3 || en_s4;
	assign en_s2 = !valid_s2 || en_s3;
	assign en_s1 = !valid_s1 || en_s2;
	assign in_ready = en_s1;

	// stage 1: clamp hue, sextant, ramp index, percent table lookups
	logic [HUE_W-1:0]  hue_c;
	logic [HUE_W-1:0]  hue_rem;
	logic [KIDX_W-1:0] hue_dist;
	logic [KIDX_W-1:0] kidx;
	sext_t             sext;

	assign hue_c = (hue_deg > HUE_MAX) ? '0 : hue_deg;

	always_comb begin
		if (hue_c < HUE_60) begin
			sext = SEXT_0;
		end else if (hue_c < HUE_120) begin
			sext = SEXT_1;
		end else if (hue_c < HUE_180) begin
			sext = SEXT_2;
		end else if (hue_c < HUE_240) begin
			sext = SEXT_3;
		end else if (hue_c < HUE_300) begin
			sext = SEXT_4;
		end else begin
			sext = SEXT_5;
		end
	end

	always_comb begin
		if (hue_c < HUE_120) begin
			hue_rem = hue_c;
		end else if (hue_c < HUE_240) begin
			hue_rem = hue_c - HUE_120;
		end else begin
			hue_rem = hue_c - HUE_240;
		end
		if (hue_rem >= HUE_60) begin
			hue_dist = KIDX_W'(hue_rem - HUE_60);
		end else begin
			hue_dist = KIDX_W'(HUE_60 - hue_rem);
		end
		kidx = KIDX_W'(HUE_60) - hue_dist;
	end

	logic [QW-1:0]     s_s1, v_s1;
	logic [KIDX_W-1:0] kidx_s1;
	sext_t             sext_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			s_s1 <= pct_lut[sat_pct];
			v_s1 <= pct_lut[val_pct];
			kidx_s1 <= kidx;
			sext_s1 <= sext;
		end
	end

	// stage 2: chroma, hue ramp table lookup
	logic [2*QW-1:0] sv_prod;
	logic [QW-1:0]   c_s2, v_s2, k_s2;
	sext_t           sext_s2;

	assign sv_prod = s_s1 * v_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2 && valid_s1) begin
			c_s2 <= sv_prod[FRAC_BITS +: QW];
			v_s2 <= v_s1;
			k_s2 <= k_lut[kidx_s1];
			sext_s2 <= sext_s1;
		end
	end

	// stage 3: secondary component and offset
	logic [2*QW-1:0] ck_prod;
	logic [QW-1:0]   c_s3, x_s3, m_s3;
	sext_t           sext_s3;

	assign ck_prod = c_s2 * k_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en_s3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3 && valid_s2) begin
			c_s3 <= c_s2;
			x_s3 <= ck_prod[FRAC_BITS +: QW];
			m_s3 <= v_s2 - c_s2;
			sext_s3 <= sext_s2;
		end
	end

	// stage 4: place components, add offset, scale to bytes
	logic [QW-1:0]     r_cmp, g_cmp, b_cmp;
	logic [QW-1:0]     r_lvl, g_lvl, b_lvl;
	logic [CHAN_W-1:0] r_code, g_code, b_code;
	logic [CHAN_W-1:0] red_s4, green_s4, blue_s4;

	always_comb begin
		case (sext_s3)
			SEXT_0: begin
				r_cmp = c_s3; g_cmp = x_s3; b_cmp = '0;
			end
			SEXT_1: begin
				r_cmp = x_s3; g_cmp = c_s3; b_cmp = '0;
			end
			SEXT_2: begin
				r_cmp = '0; g_cmp = c_s3; b_cmp = x_s3;
			end
			SEXT_3: begin
				r_cmp = '0; g_cmp = x_s3; b_cmp = c_s3;
			end
			SEXT_4: begin
				r_cmp = x_s3; g_cmp = '0; b_cmp = c_s3;
			end
			default: begin
				r_cmp = c_s3; g_cmp = '0; b_cmp = x_s3;
			end
		endcase
	end

	assign r_lvl = r_cmp + m_s3;
	assign g_lvl = g_cmp + m_s3;
	assign b_lvl = b_cmp + m_s3;

	hsv2rgb_chan #(.FRAC_BITS(FRAC_BITS)) u_chan_r (.level(r_lvl), .code(r_code));
	hsv2rgb_chan #(.FRAC_BITS(FRAC_BITS)) u_chan_g (.level(g_lvl), .code(g_code));
	hsv2rgb_chan #(.FRAC_BITS(FRAC_BITS)) u_chan_b (.level(b_lvl), .code(b_code));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en_s4) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4 && valid_s3) begin
			red_s4 <= r_code;
			green_s4 <= g_code;
			blue_s4 <= b_code;
		end
	end

	assign out_valid = valid_s4;
	assign red = red_s4;
	assign green = green_s4;
	assign blue = blue_s4;

	`HSV2RGB_ASSERT(a_chroma_le_value, !valid_s2 || (c_s2 <= v_s2), "chroma above value")
	`HSV2RGB_ASSERT(a_x_le_chroma, !valid_s3 || (x_s3 <= c_s3), "secondary above chroma")
	`HSV2RGB_ASSERT_NEXT(a_accept_enters, in_valid && in_ready, valid_s1, "accepted item lost")
	`HSV2RGB_ASSERT_NEXT(a_stall_holds, valid_s4 && !out_ready, valid_s4, "stalled item dropped")

endmodule

>>> rtl/core/hsv2rgb_chan.sv
// Scales one fixed-point channel level to an 8-bit code, truncating and saturating.
// Depends on hsv2rgb_pkg.
module hsv2rgb_chan import hsv2rgb_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic [FRAC_BITS:0]  level,
	output logic [CHAN_W-1:0]   code
);

	localparam int QW = FRAC_BITS + 1;
	localparam int SW = QW + CHAN_W;

	logic [SW-1:0]     scaled;
	logic [CHAN_W:0]   whole;

	// level * 255 as a shift and subtract
	assign scaled = {level, {CHAN_W{1'b0}}} - SW'(level);
	assign whole = scaled[FRAC_BITS +: CHAN_W + 1];
	assign code = (whole > {1'b0, CHAN_MAX}) ? CHAN_MAX : whole[CHAN_W-1:0];

endmodule

>>> tb/rgb_result_check.sv
`timescale 1ns / 100ps
// Checker for the HSV to RGB converter: predicts each color from the accepted HSV item.
// Compares every accepted output item against the oldest prediction.
// Depends on hsv2rgb_pkg.
module rgb_result_check import hsv2rgb_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_ready,
	input  logic [HUE_W-1:0]  hue_deg,
	input  logic [PCT_W-1:0]  sat_pct,
	input  logic [PCT_W-1:0]  val_pct,
	input  logic              out_valid,
	input  logic              out_ready,
	input  logic [CHAN_W-1:0] red,
	input  logic [CHAN_W-1:0] green,
	input  logic [CHAN_W-1:0] blue,
	output int                mismatch_count,
	output int                colors_in_flight
);

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
	} rgb_t;

	rgb_t expected_colors[$];

	function automatic rgb_t hsv_color_to_rgb(input logic [HUE_W-1:0] h,
			input logic [PCT_W-1:0] s_in, input logic [PCT_W-1:0] v_in);
		longint unsigned hue, sat, val, s_q, v_q, c_q, x_q, m_q, f, hue_dist, k_q, q;
		longint unsigned comp[3];
		logic [CHAN_W-1:0] chan[3];
		sext_t sext;
		rgb_t res;
		hue = (h > HUE_MAX) ? 0 : h;
		sat = (s_in > PCT_MAX) ? 0 : s_in;
		val = (v_in > PCT_MAX) ? 0 : v_in;
		s_q = (sat << FRAC_BITS) / PCT_MAX;
		v_q = (val << FRAC_BITS) / PCT_MAX;
		c_q = (s_q * v_q) >> FRAC_BITS;
		f = hue % HUE_120;
		hue_dist = (f >= HUE_60) ? (f - HUE_60) : (HUE_60 - f);
		k_q = ((HUE_60 - hue_dist) << FRAC_BITS) / HUE_60;
		x_q = (c_q * k_q) >> FRAC_BITS;
		m_q = v_q - c_q;
		if (hue >= HUE_300)
			sext = SEXT_5;
		else if (hue >= HUE_240)
			sext = SEXT_4;
		else if (hue >= HUE_180)
			sext = SEXT_3;
		else if (hue >= HUE_120)
			sext = SEXT_2;
		else if (hue >= HUE_60)
			sext = SEXT_1;
		else
			sext = SEXT_0;
		case (sext)
			SEXT_0: comp = '{c_q, x_q, 0};
			SEXT_1: comp = '{x_q, c_q, 0};
			SEXT_2: comp = '{0, c_q, x_q};
			SEXT_3: comp = '{0, x_q, c_q};
			SEXT_4: comp = '{x_q, 0, c_q};
			default: comp = '{c_q, 0, x_q};
		endcase
		for (int i = 0; i < 3; i++) begin
			q = ((comp[i] + m_q) * CHAN_MAX) >> FRAC_BITS;
			chan[i] = (q > CHAN_MAX) ? CHAN_MAX : q[CHAN_W-1:0];
		end
		res.red = chan[0];
		res.green = chan[1];
		res.blue = chan[2];
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rgb_t exp_c;
		if (!arst_n) begin
			expected_colors.delete();
			mismatch_count <= 0;
			colors_in_flight <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_colors.size() == 0) begin
					$display("%0t: unexpected output item r=%0d g=%0d b=%0d",
						$time, red, green, blue);
					mismatch_count <= mismatch_count + 1;
				end else begin
					exp_c = expected_colors.pop_front();
					if (red !== exp_c.red)
						$display("%0t: red expected %0d actual %0d", $time, exp_c.red, red);
					if (green !== exp_c.green)
						$display("%0t: green expected %0d actual %0d",
							$time, exp_c.green, green);
					if (blue !== exp_c.blue)
						$display("%0t: blue expected %0d actual %0d", $time, exp_c.blue, blue);
					if (red !== exp_c.red || green !== exp_c.green || blue !== exp_c.blue)
						mismatch_count <= mismatch_count + 1;
				end
			end
			if (in_valid && in_ready)
				expected_colors.push_back(hsv_color_to_rgb(hue_deg, sat_pct, val_pct));
			colors_in_flight <= expected_colors.size();
		end
	end

endmodule

>>> tb/hsv_to_rgb_converter_tb.sv
`timescale 1ns / 100ps
// Testbench top for hsv_to_rgb_converter: drives HSV items and output back-pressure.
// Depends on hsv2rgb_pkg, the converter RTL and rgb_result_check.
module hsv_to_rgb_converter_tb;
	import hsv2rgb_pkg::*;

	localparam int FRAC_BITS = 16;
	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_CYCLES = 300;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic [HUE_W-1:0]  hue_deg;
	logic [PCT_W-1:0]  sat_pct;
	logic [PCT_W-1:0]  val_pct;
	logic              out_valid;
	logic              out_ready;
	logic [CHAN_W-1:0] red;
	logic [CHAN_W-1:0] green;
	logic [CHAN_W-1:0] blue;

	int mismatch_count;
	int colors_in_flight;
	int quiet_cycles;
	bit tx_idle_on;
	bit rx_idle_on;
	bit hold_req;

	hsv_to_rgb_converter #(.FRAC_BITS(FRAC_BITS)) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.hue_deg   (hue_deg),
		.sat_pct   (sat_pct),
		.val_pct   (val_pct),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.red       (red),
		.green     (green),
		.blue      (blue)
	);

	rgb_result_check #(.FRAC_BITS(FRAC_BITS)) u_rgb_check (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.hue_deg          (hue_deg),
		.sat_pct          (sat_pct),
		.val_pct          (val_pct),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.red              (red),
		.green            (green),
		.blue             (blue),
		.mismatch_count   (mismatch_count),
		.colors_in_flight (colors_in_flight)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	task automatic send_color(input logic [HUE_W-1:0] h, input logic [PCT_W-1:0] s,
			input logic [PCT_W-1:0] v);
		while (tx_idle_on && $urandom_range(99) < 34) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		hue_deg <= h;
		sat_pct <= s;
		val_pct <= v;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic send_random_colors(input int count);
		logic [HUE_W-1:0] h;
		logic [PCT_W-1:0] s, v;
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(9))
				0: h = HUE_W'($urandom);
				1: h = $urandom_range(1) ? HUE_MAX : HUE_W'($urandom_range(7) * HUE_60);
				default: h = HUE_W'($urandom_range(HUE_MAX));
			endcase
			s = ($urandom_range(9) == 0) ? PCT_W'($urandom) : PCT_W'($urandom_range(PCT_MAX));
			v = ($urandom_range(9) == 0) ? PCT_W'($urandom) : PCT_W'($urandom_range(PCT_MAX));
			if ($urandom_range(19) == 0)
				s = $urandom_range(1) ? PCT_MAX : '0;
			if ($urandom_range(19) == 0)
				v = $urandom_range(1) ? PCT_MAX : '0;
			send_color(h, s, v);
		end
	endtask

	task automatic drain_colors();
		in_valid <= 1'b0;
		@(posedge clk);
		wait (colors_in_flight == 0);
	endtask

	// back-pressure on the output side
	initial begin
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				out_ready <= rx_idle_on ? ($urandom_range(99) >= 34) : 1'b1;
			end
		end
	end

	initial begin
		quiet_cycles = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		hue_deg = '0;
		sat_pct = '0;
		val_pct = '0;
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		hold_req = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_color(9'd0, 7'd0, 7'd0);
		send_color(9'd0, PCT_MAX, PCT_MAX);
		send_color(9'd30, PCT_MAX, PCT_MAX);
		send_color(9'd59, PCT_MAX, PCT_MAX);
		send_color(HUE_60, PCT_MAX, PCT_MAX);
		send_color(9'd90, 7'd50, 7'd50);
		send_color(9'd119, PCT_MAX, PCT_MAX);
		send_color(HUE_120, PCT_MAX, PCT_MAX);
		send_color(HUE_180, PCT_MAX, 7'd75);
		send_color(HUE_240, 7'd33, PCT_MAX);
		send_color(HUE_300, PCT_MAX, PCT_MAX);
		send_color(9'd359, PCT_MAX, PCT_MAX);
		send_color(HUE_MAX, PCT_MAX, PCT_MAX);
		send_color(HUE_MAX, 7'd0, PCT_MAX);
		send_color(9'd361, PCT_MAX, PCT_MAX);
		send_color(9'd511, 7'd127, 7'd127);
		send_color(9'd100, 7'd101, PCT_MAX);
		send_color(9'd100, PCT_MAX, 7'd101);
		send_color(9'd200, 7'd127, 7'd80);
		send_color(9'd511, 7'd0, 7'd0);
		send_color(9'd1, 7'd1, 7'd1);
		send_color(9'd255, 7'd64, 7'd64);
		send_color(9'd170, 7'd85, 7'd42);
		drain_colors();

		send_random_colors(400);
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		send_random_colors(300);

		// fill the pipeline while the output is held off
		hold_req = 1'b1;
		send_random_colors(60);
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		send_random_colors(150);
		drain_colors();

		send_random_colors(220);
		rx_idle_on = 1'b0;
		send_random_colors(100);
		rx_idle_on = 1'b1;
		tx_idle_on = 1'b0;
		send_random_colors(100);
		drain_colors();

		repeat (20) @(posedge clk);
		if (mismatch_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/hsv2rgb_pkg.sv
rtl/core/hsv2rgb_chan.sv
rtl/core/hsv_to_rgb_converter.sv
tb/rgb_result_check.sv
tb/hsv_to_rgb_converter_tb.sv
